[hdl/oxy_pkg.sv]
// oxy_pkg: shared types, constants and helpers for the oxygen sensor readout block
// used by the divider, the front end, the job queue, the back end and the top level
`timescale 1ns / 1ps

package oxy_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int TIME_W    = 32;
	localparam int TENTHS_W  = 14;
	localparam int MVH_W     = 15;
	localparam int REF_W     = 16;
	localparam int ASUM_W    = 17;
	localparam int SUM_W     = 18;
	localparam int CNT_W     = 2;
	localparam int ACT_W     = 15;
	localparam int DEB_W     = 16;
	localparam int FLOOR_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int MENU_W    = 2;

	// divider operand widths, sized for a full window of three
	localparam int NUM_W = 26;
	localparam int DEN_W = 19;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [TENTHS_W-1:0] TENTHS_MAX = 14'd9999;
	localparam logic [MVH_W-1:0]    MVH_MAX    = 15'd25600;

	// 2 * 209 for round-half-up of a * 20.9 / ref in tenths
	localparam int O2_SCALE   = 418;
	localparam int MV_SCALE   = 200;
	localparam int MV_BIAS_SH = 7;
	localparam int MV_DIV_SH  = 8;

	localparam logic [ACT_W-1:0]  ACT_PRESS    = 15'd17;
	localparam logic [ACT_W-1:0]  MENU_MIN_ACT = 15'd16;
	localparam logic [TIME_W-1:0] HOLD_MIN_MS  = 32'd2;
	localparam logic [TIME_W-1:0] MS_ONE_S     = 32'd1000;
	localparam logic [TIME_W-1:0] MS_TWO_S     = 32'd2000;
	localparam logic [TIME_W-1:0] MS_THREE_S   = 32'd3000;

	// floor(x / 3) as (x * 43691) >> 17, exact for x below 2^17
	localparam logic [ASUM_W-1:0] RECIP3    = 17'd43691;
	localparam int                RECIP3_SH = 17;

	localparam logic [MENU_W-1:0] MENU_NONE = 2'd0;
	localparam logic [MENU_W-1:0] MENU_CAL  = 2'd1;
	localparam logic [MENU_W-1:0] MENU_MODE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_START_CAL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_FLOOR = 2'd3;

	localparam logic [REF_W-1:0]    START_CAL_RST   = 16'd0;
	localparam logic [DEB_W-1:0]    DEBOUNCE_RST    = 16'd200;
	localparam logic [TENTHS_W-1:0] ALARM_RST       = 14'd400;
	localparam logic [FLOOR_W-1:0]  ERROR_FLOOR_RST = 16'd8;

	typedef struct packed {
		logic [DEB_W-1:0]   debounce;
		logic [FLOOR_W-1:0] err_floor;
		logic               cal_load;
		logic [REF_W-1:0]   cal_value;
	} front_cfg_t;

	typedef struct packed {
		logic [ASUM_W-1:0] asum;
		logic [CNT_W-1:0]  cnt;
		logic [REF_W-1:0]  ref_lvl;
		logic              err;
		logic              mode;
		logic [MENU_W-1:0] menu;
		logic              dot;
	} job_t;

	// floor(x / d) for a window count of one to three
	function automatic logic [ASUM_W-1:0] div_small(input logic [ASUM_W-1:0] x,
		input logic [CNT_W-1:0] d);
		logic [2*ASUM_W-1:0] prod;
		logic [ASUM_W-1:0]   res;
		prod = (2*ASUM_W)'(x) * (2*ASUM_W)'(RECIP3);
		case (d)
			2'd1:    res = x;
			2'd2:    res = x >> 1;
			2'd3:    res = prod[RECIP3_SH +: ASUM_W];
			default: res = '0;
		endcase
		return res;
	endfunction

endpackage

[hdl/oxy_div.sv]
// oxy_div: restoring divider, one quotient bit per cycle
// depends on oxy_pkg for operand widths
`timescale 1ns / 1ps

module oxy_div
	import oxy_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int STEP_W = $clog2(NUM_W);

	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] diff;
	logic           ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[NUM_W-1]};
		diff   = rem_sh - {1'b0, den_q};
		ge     = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// numerator shifts out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;

endmodule

[hdl/oxy_fifo.sv]
// oxy_fifo: short job queue between the front end and the back end
// depends on oxy_pkg for job_t and the queue depth
`timescale 1ns / 1ps

module oxy_fifo
	import oxy_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	job_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_QW-1:0] count_q;

	assign full    = (count_q == CNT_QW'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("job queue overflow");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue underflow");

endmodule

[hdl/oxy_front.sv]
// oxy_front: takes sensor items, runs the button menu and the sample window,
// and hands one job per reported item to the queue; depends on oxy_pkg
`timescale 1ns / 1ps

module oxy_front
	import oxy_pkg::*;
#(
	parameter int WINDOW_LEN = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       button_pressed,
	input  logic [TIME_W-1:0]          now_ms,
	input  front_cfg_t                 cfg,
	output logic                       job_push,
	output job_t                       job,
	input  logic                       job_full
);

	localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

	logic [SAMPLE_W-1:0] win_q [WINDOW_LEN];
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    fill_q;
	logic [TIME_W-1:0]   press_q;
	logic                prior_q;
	logic [ACT_W-1:0]    act_q;
	logic                mode_q;
	logic [REF_W-1:0]    ref_q;
	logic                hold_q;

	logic              pend_s1, pend_s2;
	logic              calib_s1, sec1_s1, sec2_s1;
	logic              calib_s2, sec1_s2, sec2_s2;
	logic [ASUM_W-1:0] asum_s2;

	logic              accept;
	logic              hold_skip;
	logic              prior_eff;
	logic [ACT_W-1:0]  act_eff;
	logic [TIME_W-1:0] since;
	logic [TIME_W-1:0] held;
	logic              press_edge;
	logic              release_ev;
	logic              is0, is1, is2;

	logic [SUM_W-1:0]  sum_w;
	logic [ASUM_W-1:0] abs_w;

	logic [ASUM_W-1:0]    cal_avg;
	logic [REF_W-1:0]     ref_now;
	logic [ACT_W-1:0]     act_now;
	logic [ASUM_W+1:0]    err_lhs;
	logic [FLOOR_W+1:0]   err_rhs;
	logic                 err_now;
	logic [MENU_W-1:0]    menu_now;

	assign in_stall = pend_s1 | pend_s2;
	assign accept   = in_valid & ~in_stall;

	// button decode for the item at the port
	always_comb begin
		hold_skip  = hold_q & ~button_pressed;
		prior_eff  = hold_q ? 1'b0 : prior_q;
		act_eff    = hold_q ? '0 : act_q;
		since      = now_ms - press_q;
		press_edge = button_pressed & ~prior_eff & (since > TIME_W'(cfg.debounce));
		held       = press_edge ? '0 : since;
		release_ev = (held > HOLD_MIN_MS) & ~button_pressed & prior_eff;
		is0        = (held < MS_ONE_S);
		is1        = (held >= MS_ONE_S) & (held < MS_TWO_S);
		is2        = (held >= MS_TWO_S) & (held < MS_THREE_S);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			fill_q  <= '0;
			press_q <= '0;
			prior_q <= 1'b0;
			act_q   <= '0;
			mode_q  <= 1'b0;
			ref_q   <= START_CAL_RST;
			hold_q  <= 1'b0;
			pend_s1 <= 1'b0;
			pend_s2 <= 1'b0;
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (cfg.cal_load) begin
				ref_q <= cfg.cal_value;
			end
			if (accept && !hold_skip) begin
				if (release_ev && is0) begin
					// short press: freeze the display
					hold_q  <= 1'b1;
					act_q   <= '0;
					prior_q <= 1'b0;
				end else begin
					hold_q        <= 1'b0;
					prior_q       <= button_pressed;
					act_q         <= press_edge ? ACT_PRESS : act_eff;
					win_q[slot_q] <= sample;
					slot_q        <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
					if (fill_q < CNT_W'(WINDOW_LEN)) begin
						fill_q <= fill_q + 1'b1;
					end
					if (press_edge) begin
						press_q <= now_ms;
					end
					if (release_ev && is2) begin
						mode_q <= ~mode_q;
					end
					pend_s1 <= 1'b1;
				end
			end
			if (pend_s1) begin
				pend_s1 <= 1'b0;
				pend_s2 <= 1'b1;
			end
			if (pend_s2 && !job_full) begin
				pend_s2 <= 1'b0;
				act_q   <= act_now + 1'b1;
				if (calib_s2) begin
					ref_q <= ref_now;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			calib_s1 <= release_ev & is1;
			sec1_s1  <= is1;
			sec2_s1  <= is2;
		end
		if (pend_s1) begin
			calib_s2 <= calib_s1;
			sec1_s2  <= sec1_s1;
			sec2_s2  <= sec2_s1;
			asum_s2  <= abs_w;
		end
	end

	// window total over the updated entries; unfilled entries still hold zero
	always_comb begin
		sum_w = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			sum_w = sum_w + {{(SUM_W-SAMPLE_W){win_q[i][SAMPLE_W-1]}}, win_q[i]};
		end
		abs_w = sum_w[SUM_W-1] ? ASUM_W'(~sum_w + 1'b1) : sum_w[ASUM_W-1:0];
	end

	always_comb begin
		cal_avg  = div_small(asum_s2, fill_q);
		ref_now  = calib_s2 ? cal_avg[REF_W-1:0] : ref_q;
		act_now  = calib_s2 ? '0 : act_q;
		err_lhs  = (ASUM_W+2)'(asum_s2) * (ASUM_W+2)'(WINDOW_LEN);
		err_rhs  = (FLOOR_W+2)'(cfg.err_floor) * (FLOOR_W+2)'(fill_q);
		err_now  = (err_lhs < (ASUM_W+2)'(err_rhs));
		menu_now = MENU_NONE;
		if (act_now > MENU_MIN_ACT) begin
			if (sec1_s2) begin
				menu_now = MENU_CAL;
			end else if (sec2_s2) begin
				menu_now = MENU_MODE;
			end
		end
		job.asum    = asum_s2;
		job.cnt     = fill_q;
		job.ref_lvl = ref_now;
		job.err     = err_now;
		job.mode    = mode_q;
		// an error shows alone on the display
		job.menu    = err_now ? MENU_NONE : menu_now;
		job.dot     = err_now ? 1'b0 : (act_now[1:0] != 2'b00);
	end

	assign job_push = pend_s2 & ~job_full;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_LEN))
		else $error("window fill count beyond window length");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q |-> (!pend_s1 && !pend_s2))
		else $error("item in flight while display is frozen");

endmodule

[hdl/oxy_back.sv]
// oxy_back: turns queued jobs into readings, with the iterative divider for
// the oxygen ratio and the output register; depends on oxy_pkg and oxy_div
`timescale 1ns / 1ps

module oxy_back
	import oxy_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_empty,
	input  job_t                job,
	output logic                job_pop,
	input  logic [TENTHS_W-1:0] alarm_level,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [TENTHS_W-1:0] oxygen_tenths,
	output logic [MVH_W-1:0]    millivolt_hundredths,
	output logic                sensor_error,
	output logic                alarm,
	output logic                advanced_mode,
	output logic [MENU_W-1:0]   menu_hint,
	output logic                activity_dot,
	output logic [REF_W-1:0]    calibration_value
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]          state_q;
	job_t                job_q;
	logic [MVH_W-1:0]    mvh_q;
	logic [TENTHS_W-1:0] tenths_q;

	logic                out_valid_q;
	logic [TENTHS_W-1:0] tenths_out_q;
	logic [MVH_W-1:0]    mvh_out_q;
	logic                err_out_q, alarm_out_q, mode_out_q, dot_out_q;
	logic [MENU_W-1:0]   menu_out_q;
	logic [REF_W-1:0]    ref_out_q;

	logic [DEN_W-2:0]  dprod;
	logic [NUM_W-1:0]  o2_num;
	logic [DEN_W-1:0]  o2_den;
	logic [24:0]       mv_num;
	logic [ASUM_W-1:0] mv_base;
	logic [ASUM_W-1:0] mv_q17;
	logic              div_start, div_busy, div_done;
	logic [NUM_W-1:0]  div_quot;
	logic              out_free;

	always_comb begin
		dprod   = (DEN_W-1)'(job_q.ref_lvl) * (DEN_W-1)'(job_q.cnt);
		o2_num  = NUM_W'(job_q.asum) * NUM_W'(O2_SCALE) + NUM_W'(dprod);
		o2_den  = {dprod, 1'b0};
		mv_num  = 25'(job_q.asum) * 25'(MV_SCALE) + (25'(job_q.cnt) << MV_BIAS_SH);
		mv_base = ASUM_W'(mv_num >> MV_DIV_SH);
		mv_q17  = div_small(mv_base, job_q.cnt);
	end

	assign div_start = (state_q == ST_PREP);
	assign job_pop   = (state_q == ST_IDLE) & ~job_empty;
	assign out_free  = ~out_valid_q | ~out_stall;

	oxy_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (o2_num),
		.den    (o2_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (state_q == ST_PREP) begin
			mvh_q <= (mv_q17 > ASUM_W'(MVH_MAX)) ? MVH_MAX : mv_q17[MVH_W-1:0];
		end
		if (state_q == ST_DIV && div_done) begin
			if (job_q.ref_lvl == '0 || div_quot > NUM_W'(TENTHS_MAX)) begin
				tenths_q <= TENTHS_MAX;
			end else begin
				tenths_q <= div_quot[TENTHS_W-1:0];
			end
		end
		if (state_q == ST_OUT && out_free) begin
			tenths_out_q <= tenths_q;
			mvh_out_q    <= mvh_q;
			err_out_q    <= job_q.err;
			alarm_out_q  <= (tenths_q > alarm_level);
			mode_out_q   <= job_q.mode;
			menu_out_q   <= job_q.menu;
			dot_out_q    <= job_q.dot;
			ref_out_q    <= job_q.ref_lvl;
		end
	end

	assign out_valid            = out_valid_q;
	assign oxygen_tenths        = tenths_out_q;
	assign millivolt_hundredths = mvh_out_q;
	assign sensor_error         = err_out_q;
	assign alarm                = alarm_out_q;
	assign advanced_mode        = mode_out_q;
	assign menu_hint            = menu_out_q;
	assign activity_dot         = dot_out_q;
	assign calibration_value    = ref_out_q;

	a_div_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_busy || div_done))
		else $error("waiting on a divider that is not running");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (tenths_out_q <= TENTHS_MAX && mvh_out_q <= MVH_MAX))
		else $error("reading outside saturation limits");

endmodule

[hdl/oxygen_sensor_readout_with_button_menu_top.sv]
// oxygen_sensor_readout_with_button_menu_top: configuration registers and
// the front end, job queue and back end; depends on oxy_pkg and all oxy_ modules
//
// Usage
//   Input channel (in_valid / in_stall) carries one sensor item: sample,
//   button_pressed and now_ms. A transfer happens when in_valid is high and
//   in_stall is low. Each item gives one reading or, in hold or on a short
//   press, none.
//   Output channel (out_valid / out_stall) carries one reading per transfer;
//   the reading stays on the port while out_stall is high.
//   Configuration (cfg_valid / cfg_ready) is always ready; index 0 loads the
//   calibration reference, 1 the debounce time, 2 the alarm level and 3 the
//   error floor. Write it only while no item is in flight.
// Timing
//   The front end takes an item through stage s1 for the window sum and
//   stage s2 for calibration and the push to the queue, so in_stall stays
//   high after each transfer that yields a reading until the job is pushed;
//   a full queue holds it there. The back end works on one reading at a
//   time, through the 26-step oxygen ratio divider; a two-entry queue lets
//   the front end run ahead while the receiver stalls.
// Reset
//   arst_n clears the window, button state and queue; the reference is zero
//   and the registers take their default values.
`timescale 1ns / 1ps

module oxygen_sensor_readout_with_button_menu_top
	import oxy_pkg::*;
#(
	parameter int WINDOW_LEN = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       button_pressed,
	input  logic [TIME_W-1:0]          now_ms,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [TENTHS_W-1:0]        oxygen_tenths,
	output logic [MVH_W-1:0]           millivolt_hundredths,
	output logic                       sensor_error,
	output logic                       alarm,
	output logic                       advanced_mode,
	output logic [MENU_W-1:0]          menu_hint,
	output logic                       activity_dot,
	output logic [REF_W-1:0]           calibration_value,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DAT_W-1:0]       cfg_data
);

	logic [DEB_W-1:0]    debounce_q;
	logic [TENTHS_W-1:0] alarm_q;
	logic [FLOOR_W-1:0]  floor_q;

	logic       cfg_wr;
	front_cfg_t fcfg;
	logic       job_push, job_full, job_pop, job_empty;
	job_t       push_job, pop_job;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			alarm_q    <= ALARM_RST;
			floor_q    <= ERROR_FLOOR_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_START_CAL:   ;
				REG_DEBOUNCE:    debounce_q <= cfg_data[DEB_W-1:0];
				REG_ALARM:       alarm_q    <= cfg_data[TENTHS_W-1:0];
				REG_ERROR_FLOOR: floor_q    <= cfg_data[FLOOR_W-1:0];
				default:         ;
			endcase
		end
	end

	// the reference itself lives in the front end
	always_comb begin
		fcfg.debounce  = debounce_q;
		fcfg.err_floor = floor_q;
		fcfg.cal_load  = cfg_wr & (cfg_index == REG_START_CAL);
		fcfg.cal_value = cfg_data[REF_W-1:0];
	end

	oxy_front #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.button_pressed (button_pressed),
		.now_ms         (now_ms),
		.cfg            (fcfg),
		.job_push       (job_push),
		.job            (push_job),
		.job_full       (job_full)
	);

	oxy_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.full     (job_full),
		.pop      (job_pop),
		.pop_job  (pop_job),
		.empty    (job_empty)
	);

	oxy_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.job_empty            (job_empty),
		.job                  (pop_job),
		.job_pop              (job_pop),
		.alarm_level          (alarm_q),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.oxygen_tenths        (oxygen_tenths),
		.millivolt_hundredths (millivolt_hundredths),
		.sensor_error         (sensor_error),
		.alarm                (alarm),
		.advanced_mode        (advanced_mode),
		.menu_hint            (menu_hint),
		.activity_dot         (activity_dot),
		.calibration_value    (calibration_value)
	);

endmodule
